// ===== rtl/mbpe_pkg.sv =====
package mbpe_pkg;

    localparam int MAX_ROW_BYTES_DEF = 32;
    localparam int JOBQ_DEPTH        = 4;
    localparam int CFG_IDX_W         = 4;

    localparam logic [1:0] KIND_CALLER = 2'd0;
    localparam logic [1:0] KIND_FORE   = 2'd1;
    localparam logic [1:0] KIND_BACK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MASKED_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 4'd7;

    typedef struct packed {
        logic        masked_mode;
        logic [7:0]  bitmap_width;
        logic [7:0]  bitmap_height;
        logic [5:0]  row_bytes;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  draw_color;
        logic [2:0]  blend_mode;
    } t_cfg;

    // One byte's worth of pixel work: bit 7 is the leftmost column.
    typedef struct packed {
        logic [7:0]  emit;
        logic [7:0]  fore;
        logic        masked;
        logic [15:0] x_base;
        logic [15:0] y;
    } t_job;

endpackage

// ===== rtl/mbpe_front.sv =====
module mbpe_front
    import mbpe_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_restart,
    input  logic i_push,
    input  logic [7:0] i_data_byte,
    output logic o_full,
    input  logic i_jobq_full,
    output logic o_jobq_push,
    output t_job o_job
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int IW = (AW > 6) ? AW : 6;
    localparam logic [7:0] MAX_RB = 8'(MAX_ROW_BYTES);

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  colmask;
        logic        masked;
        logic [15:0] x_base;
        logic [15:0] y;
    } t_s1;

    logic [7:0] r_row, n_row;
    logic [5:0] r_bir, n_bir;
    logic       r_or_plane, n_or_plane;
    logic       r_done, n_done;

    logic [7:0] r_mask_mem [MAX_ROW_BYTES];
    logic [7:0] r_and_rd;

    logic r_s1_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    logic          active, and_phase, accept, mem_we, job_go;
    logic [6:0]    bir_inc;
    logic          plane_end;
    logic [7:0]    row_inc;
    logic [IW-1:0] idx_wide;
    logic [AW-1:0] mem_idx;
    logic [7:0]    s1_emit;
    logic          s1_push, s1_move;
    logic [9:0]    col_base;

    always_comb begin
        active = !r_done && (i_cfg.bitmap_width != 8'd0) && (i_cfg.bitmap_height != 8'd0)
                 && (i_cfg.row_bytes != 6'd0) && ({2'b00, i_cfg.row_bytes} <= MAX_RB);
        and_phase = i_cfg.masked_mode && !r_or_plane;

        s1_emit = r_s1.masked ? (r_s1.colmask & (~r_and_rd | r_s1.data))
                              : (r_s1.colmask & r_s1.data);
        s1_push = r_s1_valid && (s1_emit != 8'd0);
        s1_move = !s1_push || !i_jobq_full;

        accept = i_push && s1_move;
        mem_we = accept && active && and_phase;
        job_go = accept && active && !and_phase;

        idx_wide = IW'(r_bir);
        mem_idx  = idx_wide[AW-1:0];

        bir_inc   = {1'b0, r_bir} + 7'd1;
        plane_end = bir_inc >= {1'b0, i_cfg.row_bytes};
        row_inc   = r_row + 8'd1;

        col_base = {1'b0, r_bir, 3'b000};
        for (int k = 0; k < 8; k++) begin
            n_s1.colmask[7-k] = (col_base + 10'(k)) < {2'b00, i_cfg.bitmap_width};
        end
        n_s1.data   = i_data_byte;
        n_s1.masked = i_cfg.masked_mode;
        n_s1.x_base = i_cfg.origin_x + 16'(col_base);
        n_s1.y      = i_cfg.origin_y + 16'(r_row);

        n_row      = r_row;
        n_bir      = r_bir;
        n_or_plane = r_or_plane;
        n_done     = r_done;
        if (mem_we) begin
            if (plane_end) begin
                n_bir      = 6'd0;
                n_or_plane = 1'b1;
            end else begin
                n_bir = bir_inc[5:0];
            end
        end else if (job_go) begin
            if (plane_end) begin
                n_bir      = 6'd0;
                n_or_plane = 1'b0;
                n_row      = row_inc;
                if (row_inc == 8'd0 || row_inc >= i_cfg.bitmap_height) begin
                    n_done = 1'b1;
                end
            end else begin
                n_bir = bir_inc[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row      <= 8'd0;
            r_bir      <= 6'd0;
            r_or_plane <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_bir      <= n_bir;
            r_or_plane <= n_or_plane;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= job_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_go) begin
            r_s1 <= n_s1;
        end
    end

    // Mask buffer: AND bytes written, read back for the matching OR byte.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mask_mem[mem_idx] <= i_data_byte;
        end
        if (job_go) begin
            r_and_rd <= r_mask_mem[mem_idx];
        end
    end

    assign o_full        = !s1_move;
    assign o_jobq_push   = s1_push;
    assign o_job.emit    = s1_emit;
    assign o_job.fore    = r_s1.data;
    assign o_job.masked  = r_s1.masked;
    assign o_job.x_base  = r_s1.x_base;
    assign o_job.y       = r_s1.y;

endmodule

// ===== rtl/mbpe_jobq.sv =====
module mbpe_jobq
    import mbpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PW = $clog2(JOBQ_DEPTH);
    localparam int CW = $clog2(JOBQ_DEPTH + 1);

    t_job          r_mem [JOBQ_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = r_count == CW'(JOBQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/mbpe_back.sv =====
module mbpe_back
    import mbpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_job,
    input  logic        i_jobq_empty,
    output logic        o_jobq_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_pixel_x,
    output logic [15:0] o_pixel_y,
    output logic [1:0]  o_paint_kind,
    output logic [7:0]  o_pixel_color,
    output logic [2:0]  o_pixel_blend,
    output logic        o_last_of_item
);

    logic        r_bvalid;
    logic [7:0]  r_rem;
    logic [7:0]  r_fore;
    logic        r_masked;
    logic [15:0] r_x_base;
    logic [15:0] r_y;

    logic        r_ovalid;
    logic [15:0] r_o_x, r_o_y;
    logic [1:0]  r_o_kind;
    logic [7:0]  r_o_color;
    logic [2:0]  r_o_blend;
    logic        r_o_last;

    logic [2:0]  sel;
    logic        found;
    logic [7:0]  bit_oh, rem_next;
    logic        last, advance, step, load;
    logic [1:0]  kind;

    always_comb begin
        sel   = 3'd0;
        found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!found && r_rem[7-k]) begin
                sel   = 3'(k);
                found = 1'b1;
            end
        end
        bit_oh   = 8'h80 >> sel;
        rem_next = r_rem & ~bit_oh;
        last     = rem_next == 8'd0;
        advance  = !r_ovalid || i_pop;
        step     = r_bvalid && advance;
        load     = !i_jobq_empty && (!r_bvalid || (step && last));
        if (!r_masked) begin
            kind = KIND_CALLER;
        end else if ((r_fore & bit_oh) != 8'd0) begin
            kind = KIND_FORE;
        end else begin
            kind = KIND_BACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
        end else if (load) begin
            r_bvalid <= 1'b1;
        end else if (step && last) begin
            r_bvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem    <= i_job.emit;
            r_fore   <= i_job.fore;
            r_masked <= i_job.masked;
            r_x_base <= i_job.x_base;
            r_y      <= i_job.y;
        end else if (step) begin
            r_rem <= rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (step) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_x     <= r_x_base + 16'(sel);
            r_o_y     <= r_y;
            r_o_kind  <= kind;
            r_o_color <= (kind == KIND_CALLER) ? i_cfg.draw_color : 8'd0;
            r_o_blend <= (kind == KIND_CALLER) ? i_cfg.blend_mode : 3'd0;
            r_o_last  <= last;
        end
    end

    assign o_jobq_pop     = load;
    assign o_empty        = !r_ovalid;
    assign o_pixel_x      = r_o_x;
    assign o_pixel_y      = r_o_y;
    assign o_paint_kind   = r_o_kind;
    assign o_pixel_color  = r_o_color;
    assign o_pixel_blend  = r_o_blend;
    assign o_last_of_item = r_o_last;

endmodule

// ===== rtl/mono_bitmap_pixel_expander_top.sv =====
// A byte accepted passes the front stage register, the job queue, the pixel stepper and the
// result register before its first pixel shows. One byte per cycle is taken while the job queue
// has room; pixels leave the stepper at one per cycle unless an unpopped result stalls it.
// Bytes that yield nothing (AND plane, past the image, zero size) never reach the back end.
// Reset (synchronous, active low) clears the configuration to zero, the traversal and all queues;
// the mask buffer is not cleared and holds garbage until the AND plane of a row writes it.
module mono_bitmap_pixel_expander_top
    import mbpe_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    // input item queue side
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    // result item queue side
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          o_pixel_x,
    output logic [15:0]          o_pixel_y,
    output logic [1:0]           o_paint_kind,
    output logic [7:0]           o_pixel_color,
    output logic [2:0]           o_pixel_blend,
    output logic                 o_last_of_item
);

    t_cfg r_cfg;
    logic restart;
    logic jobq_push, jobq_full, jobq_pop, jobq_empty;
    t_job job_in, job_out;

    // Any write to a known register restarts the traversal at row zero.
    assign restart = i_cfg_wr_en && (i_cfg_idx <= REG_BLEND_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_MASKED_MODE: r_cfg.masked_mode   <= i_cfg_data[0];
                REG_WIDTH:       r_cfg.bitmap_width  <= i_cfg_data[7:0];
                REG_HEIGHT:      r_cfg.bitmap_height <= i_cfg_data[7:0];
                REG_ROW_BYTES:   r_cfg.row_bytes     <= i_cfg_data[5:0];
                REG_ORIGIN_X:    r_cfg.origin_x      <= i_cfg_data;
                REG_ORIGIN_Y:    r_cfg.origin_y      <= i_cfg_data;
                REG_DRAW_COLOR:  r_cfg.draw_color    <= i_cfg_data[7:0];
                REG_BLEND_MODE:  r_cfg.blend_mode    <= i_cfg_data[2:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Front: track row/plane position, buffer AND bytes, build per-byte jobs.
    mbpe_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_restart   (restart),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .i_jobq_full (jobq_full),
        .o_jobq_push (jobq_push),
        .o_job       (job_in)
    );

    // Short queue so the front keeps taking bytes while the back emits pixels.
    mbpe_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jobq_push),
        .i_job   (job_in),
        .o_full  (jobq_full),
        .i_pop   (jobq_pop),
        .o_job   (job_out),
        .o_empty (jobq_empty)
    );

    // Back: step through the set bits of each job, one pixel per cycle unless an unpopped result stalls it.
    mbpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job          (job_out),
        .i_jobq_empty   (jobq_empty),
        .o_jobq_pop     (jobq_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_paint_kind   (o_paint_kind),
        .o_pixel_color  (o_pixel_color),
        .o_pixel_blend  (o_pixel_blend),
        .o_last_of_item (o_last_of_item)
    );

endmodule
